/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/pesw_pkg.sv */
// ----------------------------------------------------------------------------
// pesw_pkg
// shared types and constants of the polygon edge span walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pesw_pkg;

   localparam int Rows     = 240;
   localparam int FracBits = 16;
   localparam int RowW     = $clog2(Rows);
   localparam int CntW     = $clog2(Rows + 1);
   localparam int AccW     = 32;
   localparam int XW       = 16;

   localparam logic signed [XW-1:0] SpanMax = 16'sh7fff;
   localparam logic signed [XW-1:0] SpanMin = 16'sh8000;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_EDGE_X = 2'd1,
      OP_EDGE_UV = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // request and response of the serial divider
   typedef struct packed {
      logic                   start;
      logic signed [AccW-1:0] dividend;
      logic signed [15:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [AccW-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* design/pesw_divider.sv */
// ----------------------------------------------------------------------------
// pesw_divider
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pesw_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pesw_pkg::div_req_type div_req,
   output pesw_pkg::div_rsp_type      div_rsp
);

   localparam int W = pesw_pkg::AccW;

   logic            busy_ff, busy_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W:0]      rem_ff, rem_in;
   logic [W-1:0]    dsr_ff, dsr_in;
   logic            neg_ff, neg_in;
   logic            done_ff, done_in;
   logic [W-1:0]    num_abs;
   logic [W-1:0]    den_abs;
   logic [W:0]      trial;
   logic [W:0]      shifted;

   always_comb begin
      num_abs = div_req.dividend[W-1] ? W'(-div_req.dividend) : W'(div_req.dividend);
      den_abs = div_req.divisor[15] ? W'(-32'(div_req.divisor)) : W'(32'(div_req.divisor));
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      trial   = shifted - {1'b0, dsr_ff};
   end

   // one iteration per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(W);
         quo_in  = num_abs;
         rem_in  = '0;
         dsr_in  = den_abs;
         neg_in  = div_req.dividend[W-1] ^ div_req.divisor[15];
      end else if (busy_ff) begin
         if (trial[W]) begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

`default_nettype wire

/* design/pesw_span_mem.sv */
// ----------------------------------------------------------------------------
// pesw_span_mem
// per-row span tables, one read and one write port, registered read, span valid bits per row,
// texture tables zeroed by a clearing pass of one row per cycle after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pesw_span_mem (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             clear_spans,
   input  wire logic [pesw_pkg::RowW-1:0]        rd_addr,
   output logic signed [pesw_pkg::XW-1:0]        rd_left,
   output logic signed [pesw_pkg::XW-1:0]        rd_right,
   output logic [4*pesw_pkg::AccW-1:0]           rd_tex,
   input  wire logic                             wr_en,
   input  wire logic                             wr_tex_left,
   input  wire logic                             wr_tex_right,
   input  wire logic [pesw_pkg::RowW-1:0]        wr_addr,
   input  wire logic signed [pesw_pkg::XW-1:0]   wr_left,
   input  wire logic signed [pesw_pkg::XW-1:0]   wr_right,
   input  wire logic [2*pesw_pkg::AccW-1:0]      wr_uv,
   output logic                                  init_done
);

   localparam int N  = pesw_pkg::Rows;
   localparam int RW = pesw_pkg::RowW;

   logic [2*pesw_pkg::XW-1:0]   edge_mem [N];
   logic [2*pesw_pkg::AccW-1:0] ltex_mem [N];
   logic [2*pesw_pkg::AccW-1:0] rtex_mem [N];
   logic [N-1:0]                span_vld_ff;
   logic [RW-1:0]               init_cnt_ff;
   logic                        init_busy_ff;
   logic [2*pesw_pkg::XW-1:0]   edge_rd_ff;
   logic [2*pesw_pkg::AccW-1:0] ltex_rd_ff;
   logic [2*pesw_pkg::AccW-1:0] rtex_rd_ff;
   logic                        span_v_ff;

   // span array
   always_ff @(posedge clock) begin
      if (wr_en) edge_mem[wr_addr] <= {wr_left, wr_right};
      edge_rd_ff <= edge_mem[rd_addr];
      span_v_ff  <= span_vld_ff[rd_addr];
   end

   // texture arrays, zero written row by row while the clearing pass runs
   always_ff @(posedge clock) begin
      if (init_busy_ff) begin
         ltex_mem[init_cnt_ff] <= '0;
         rtex_mem[init_cnt_ff] <= '0;
      end else if (wr_en) begin
         if (wr_tex_left)  ltex_mem[wr_addr] <= wr_uv;
         if (wr_tex_right) rtex_mem[wr_addr] <= wr_uv;
      end
      ltex_rd_ff <= ltex_mem[rd_addr];
      rtex_rd_ff <= rtex_mem[rd_addr];
   end

   // clearing pass over all rows after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_cnt_ff  <= '0;
      end else if (init_busy_ff) begin
         init_cnt_ff <= init_cnt_ff + RW'(1);
         if (init_cnt_ff == RW'(N - 1)) init_busy_ff <= 1'b0;
      end
   end

   // span valid bits, cleared by reset and by clear
   always_ff @(posedge clock) begin
      if (reset) begin
         span_vld_ff <= '0;
      end else begin
         if (clear_spans) span_vld_ff <= '0;
         else if (wr_en)  span_vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign init_done = !init_busy_ff;
   assign rd_left   = span_v_ff ? edge_rd_ff[2*pesw_pkg::XW-1:pesw_pkg::XW] : pesw_pkg::SpanMax;
   assign rd_right  = span_v_ff ? edge_rd_ff[pesw_pkg::XW-1:0] : pesw_pkg::SpanMin;
   assign rd_tex    = {ltex_rd_ff, rtex_rd_ff};

endmodule

`default_nettype wire

/* design/polygon_edge_span_walker_core.sv */
// ----------------------------------------------------------------------------
// polygon_edge_span_walker_core
// scanline span tables filled by walking polygon edges
// ----------------------------------------------------------------------------
// An edge transaction is accepted, then computes the x, u and v slopes in turn
// on one shared 32-step serial divider, then the top clip (one shift-add
// multiply step per bit of the clip count, always run), then a read, compare
// and write state per covered row for the read-modify-write on the span
// memory. Horizontal and off-screen edges and clear return to idle from the
// accept. Read-row passes the read wait, read out and output states and holds
// in output until the response is taken. After reset a clearing pass over all
// 240 rows zeroes the texture tables. req_tready is high only while the
// sequencer is idle and the clearing pass is done.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module polygon_edge_span_walker_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // operation[1:0], first_x, first_y, first_u, first_v, second_x, second_y,
   // second_u, second_v (14 bits each), row_index[7:0], zero fill to 128
   input  wire logic [127:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // span_left[15:0], span_right[15:0], left_u, left_v, right_u, right_v
   output logic [159:0]       rsp_tdata
);

   localparam int W  = pesw_pkg::AccW;
   localparam int FB = pesw_pkg::FracBits;
   localparam int RW = pesw_pkg::RowW;
   localparam int CW = pesw_pkg::CntW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_CLIP, ST_RD, ST_CMP, ST_WR,
      ST_READ_WAIT, ST_READ_OUT, ST_OUT
   } state_type;

   state_type                 state_ff, state_in;
   pesw_pkg::op_type          op_ff;
   logic signed [13:0]        x0_ff, y0_ff, u0_ff, v0_ff, x1_ff, y1_ff, u1_ff, v1_ff;
   logic [7:0]                ridx_ff;
   logic [1:0]                sel_ff;
   logic [W-1:0]              ax_ff, au_ff, av_ff, dx_ff, du_ff, dv_ff;
   logic [W-1:0]              mx_ff, mu_ff, mv_ff;
   logic [W-1:0]              nclip_ff;
   logic [5:0]                bit_ff;
   logic [RW-1:0]             row_ff;
   logic [CW-1:0]             last_ff;
   logic [159:0]              out_ff;
   logic                      out_v_ff;

   pesw_pkg::div_req_type     div_req;
   pesw_pkg::div_rsp_type     div_rsp;

   logic signed [14:0]        top_s, bot_s;
   logic                      skip;
   logic signed [15:0]        dy;
   logic signed [13:0]        n0, n1;
   logic signed [14:0]        diff;

   logic [RW-1:0]             rd_addr;
   logic signed [15:0]        rd_left, rd_right, tx;
   logic [4*W-1:0]            rd_tex;
   logic                      lt, gt;
   logic                      mem_ready;
   logic                      req_acc;

   // unpack the request fields
   logic [1:0]                f_op;
   assign f_op = req_tdata[1:0];

   // edge geometry from the request
   always_comb begin
      logic signed [13:0] ya, yb;
      ya = req_tdata[29:16];
      yb = req_tdata[85:72];
      top_s = (ya > yb) ? 15'(yb) : 15'(ya);
      bot_s = (ya > yb) ? 15'(ya) + 15'sd1 : 15'(yb) + 15'sd1;
      skip  = (ya == yb) || (top_s > 15'(pesw_pkg::Rows - 1)) || (bot_s <= 15'sd0);
   end

   // divider operands for the slope being computed
   always_comb begin
      case (sel_ff)
         2'd0:    begin n0 = x0_ff; n1 = x1_ff; end
         2'd1:    begin n0 = u0_ff; n1 = u1_ff; end
         default: begin n0 = v0_ff; n1 = v1_ff; end
      endcase
      diff = 15'(n1) - 15'(n0);
      dy   = 16'(y1_ff) - 16'(y0_ff);
      div_req.start    = (state_ff == ST_DIV_GO);
      div_req.dividend = W'(32'(diff) <<< FB);
      div_req.divisor  = dy;
   end

   pesw_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // span compare
   assign tx      = 16'(ax_ff >> FB);
   assign lt      = tx < rd_left;
   assign gt      = tx > rd_right;
   assign rd_addr = (state_ff == ST_IDLE) ? RW'(req_tdata[121:114]) :
                    (state_ff == ST_READ_WAIT) ? RW'(ridx_ff) : row_ff;

   pesw_span_mem u_mem (
      .clock        (clock),
      .reset        (reset),
      .clear_spans  (req_acc && f_op == 2'(pesw_pkg::OP_CLEAR)),
      .rd_addr      (rd_addr),
      .rd_left      (rd_left),
      .rd_right     (rd_right),
      .rd_tex       (rd_tex),
      .wr_en        (state_ff == ST_CMP && (lt || gt)),
      .wr_tex_left  (lt && op_ff == pesw_pkg::OP_EDGE_UV),
      .wr_tex_right (gt && op_ff == pesw_pkg::OP_EDGE_UV),
      .wr_addr      (row_ff),
      .wr_left      (lt ? tx : rd_left),
      .wr_right     (gt ? tx : rd_right),
      .wr_uv        ({au_ff, av_ff}),
      .init_done    (mem_ready)
   );

   assign req_tready = (state_ff == ST_IDLE) && mem_ready;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc) begin
               case (f_op)
                  2'(pesw_pkg::OP_CLEAR): state_in = ST_IDLE;
                  2'(pesw_pkg::OP_READ):  state_in = ST_READ_WAIT;
                  default:                state_in = skip ? ST_IDLE : ST_DIV_GO;
               endcase
            end
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:
            if (div_rsp.done) state_in = (sel_ff == 2'd2) ? ST_CLIP : ST_DIV_GO;
         ST_CLIP:      if (bit_ff == 6'd0) state_in = ST_RD;
         ST_RD:        state_in = ST_CMP;
         ST_CMP:       state_in = ST_WR;
         ST_WR:        state_in = (CW'(row_ff) + CW'(1) >= last_ff) ? ST_IDLE : ST_RD;
         ST_READ_WAIT: state_in = ST_READ_OUT;
         ST_READ_OUT:  state_in = ST_OUT;
         ST_OUT:       if (rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_READ_OUT) out_v_ff <= 1'b1;
         else if (rsp_tready)         out_v_ff <= 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            op_ff   <= pesw_pkg::op_type'(f_op);
            x0_ff   <= req_tdata[15:2];
            y0_ff   <= req_tdata[29:16];
            u0_ff   <= req_tdata[43:30];
            v0_ff   <= req_tdata[57:44];
            x1_ff   <= req_tdata[71:58];
            y1_ff   <= req_tdata[85:72];
            u1_ff   <= req_tdata[99:86];
            v1_ff   <= req_tdata[113:100];
            ridx_ff <= req_tdata[121:114];
            sel_ff  <= 2'd0;
            ax_ff   <= W'(32'(signed'(req_tdata[15:2])) <<< FB);
            au_ff   <= W'(32'(signed'(req_tdata[43:30])) <<< FB);
            av_ff   <= W'(32'(signed'(req_tdata[57:44])) <<< FB);
            nclip_ff <= (top_s < 0) ? W'(-32'(top_s)) : '0;
            row_ff  <= (top_s < 0) ? '0 : RW'(top_s);
            last_ff <= (bot_s > 15'(pesw_pkg::Rows)) ? CW'(pesw_pkg::Rows) : CW'(bot_s);
            bit_ff  <= 6'd32;
         end
         ST_DIV_WAIT:
            if (div_rsp.done) begin
               case (sel_ff)
                  2'd0:    begin dx_ff <= div_rsp.quotient; mx_ff <= div_rsp.quotient; end
                  2'd1:    begin du_ff <= div_rsp.quotient; mu_ff <= div_rsp.quotient; end
                  default: begin dv_ff <= div_rsp.quotient; mv_ff <= div_rsp.quotient; end
               endcase
               sel_ff <= sel_ff + 2'd1;
            end
         ST_CLIP:
            // shift-add multiply of the clip count by copies of the slopes
            if (bit_ff != 6'd0) begin
               if (nclip_ff[0]) begin
                  ax_ff <= ax_ff + mx_ff;
                  au_ff <= au_ff + mu_ff;
                  av_ff <= av_ff + mv_ff;
               end
               mx_ff    <= mx_ff << 1;
               mu_ff    <= mu_ff << 1;
               mv_ff    <= mv_ff << 1;
               nclip_ff <= nclip_ff >> 1;
               bit_ff   <= bit_ff - 6'd1;
            end
         ST_WR: begin
            ax_ff  <= ax_ff + dx_ff;
            au_ff  <= au_ff + du_ff;
            av_ff  <= av_ff + dv_ff;
            row_ff <= row_ff + RW'(1);
         end
         ST_READ_OUT:
            out_ff <= (ridx_ff < 8'(pesw_pkg::Rows)) ?
                      {rd_tex[W-1:0], rd_tex[2*W-1:W], rd_tex[3*W-1:2*W],
                       rd_tex[4*W-1:3*W], rd_right, rd_left}
                    : {128'd0, pesw_pkg::SpanMin, pesw_pkg::SpanMax};
         default: ;
      endcase
   end

   `ASSERT_IMPLIES(a_rsp_only_read, clock, reset, rsp_tvalid, state_ff == ST_OUT, "response outside read")
   `ASSERT_IMPLIES(a_div_only_busy, clock, reset, div_rsp.done, $past(state_ff) == ST_DIV_WAIT, "stray divider done")
   `ASSERT_ALWAYS(a_row_range, clock, reset, CW'(row_ff) < CW'(pesw_pkg::Rows) || state_ff == ST_IDLE || state_ff == ST_OUT || state_ff == ST_READ_WAIT || state_ff == ST_READ_OUT, "row out of range")

endmodule

`default_nettype wire

/* test/polygon_edge_span_walker_core_tb.sv */
// ----------------------------------------------------------------------------
// polygon_edge_span_walker_core_tb
// self-checking bench for the edge span walker: directed edges, clipping,
// clear and read-out, then random polygons and reads, each of a random row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polygon_edge_span_walker_core_tb;

   localparam int NumRows = 240;

   // last declared field in the lowest bits
   typedef struct packed {
      logic [31:0]        right_v;
      logic [31:0]        right_u;
      logic [31:0]        left_v;
      logic [31:0]        left_u;
      logic signed [15:0] span_right;
      logic signed [15:0] span_left;
   } span_rec;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [159:0]  rsp_tdata;

   // shadow span tables
   logic signed [15:0] lo_x [NumRows];
   logic signed [15:0] hi_x [NumRows];
   logic [31:0]        lo_u [NumRows];
   logic [31:0]        lo_v [NumRows];
   logic [31:0]        hi_u [NumRows];
   logic [31:0]        hi_v [NumRows];

   span_rec pending_spans[$];
   int      errors = 0;
   bit      quiet_tail = 0;
   bit      long_hold = 0;
   int      gap_pct = 30;

   polygon_edge_span_walker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // slope in 16.16, truncating toward zero
   function automatic logic [31:0] edge_slope(int a, int b, int dy);
      longint num;
      num = longint'(b - a) * 65536;
      return 32'(num / dy);
   endfunction

   function automatic void clear_spans();
      for (int i = 0; i < NumRows; i++) begin
         lo_x[i] = pesw_pkg::SpanMax;
         hi_x[i] = pesw_pkg::SpanMin;
      end
   endfunction

   function automatic void walk_edge(int x0, int y0, int u0, int v0,
                                     int x1, int y1, int u1, int v1, bit with_uv);
      int top, bot, dy;
      logic [31:0] ax, au, av, dx, du, dv, n;
      logic signed [31:0] sh;
      logic signed [15:0] tx;
      if (y0 == y1) return;
      if (y0 > y1) begin
         top = y1; bot = y0 + 1;
      end else begin
         top = y0; bot = y1 + 1;
      end
      if (top > NumRows - 1 || bot < 0) return;
      if (bot > NumRows) bot = NumRows;
      dy = y1 - y0;
      ax = 32'(x0 * 65536);
      au = 32'(u0 * 65536);
      av = 32'(v0 * 65536);
      dx = edge_slope(x0, x1, dy);
      du = edge_slope(u0, u1, dy);
      dv = edge_slope(v0, v1, dy);
      if (top < 0) begin
         n = 32'(-top);
         ax += n * dx; au += n * du; av += n * dv;
         top = 0;
      end
      for (int i = top; i < bot; i++) begin
         sh = $signed(ax) >>> 16;
         tx = sh[15:0];
         if (tx < lo_x[i]) begin
            lo_x[i] = tx;
            if (with_uv) begin
               lo_u[i] = au; lo_v[i] = av;
            end
         end
         if (tx > hi_x[i]) begin
            hi_x[i] = tx;
            if (with_uv) begin
               hi_u[i] = au; hi_v[i] = av;
            end
         end
         ax += dx; au += du; av += dv;
      end
   endfunction

   // send one transaction and update the shadow tables
   task automatic send_item(pesw_pkg::op_type op, int x0, int y0, int u0, int v0,
                            int x1, int y1, int u1, int v1, int row);
      logic [127:0] d;
      span_rec s;
      d = '0;
      d[1:0]     = op;
      d[15:2]    = 14'(x0);
      d[29:16]   = 14'(y0);
      d[43:30]   = 14'(u0);
      d[57:44]   = 14'(v0);
      d[71:58]   = 14'(x1);
      d[85:72]   = 14'(y1);
      d[99:86]   = 14'(u1);
      d[113:100] = 14'(v1);
      d[121:114] = 8'(row);
      if (!quiet_tail && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      // shadow uses the truncated field values
      case (op)
         pesw_pkg::OP_CLEAR:   clear_spans();
         pesw_pkg::OP_EDGE_X:  walk_edge($signed(d[15:2]), $signed(d[29:16]),
                        $signed(d[43:30]), $signed(d[57:44]), $signed(d[71:58]),
                        $signed(d[85:72]), $signed(d[99:86]), $signed(d[113:100]), 1'b0);
         pesw_pkg::OP_EDGE_UV: walk_edge($signed(d[15:2]), $signed(d[29:16]),
                        $signed(d[43:30]), $signed(d[57:44]), $signed(d[71:58]),
                        $signed(d[85:72]), $signed(d[99:86]), $signed(d[113:100]), 1'b1);
         default: begin
            if (d[121:114] < NumRows) begin
               s.span_left  = lo_x[d[121:114]];
               s.span_right = hi_x[d[121:114]];
               s.left_u  = lo_u[d[121:114]];
               s.left_v  = lo_v[d[121:114]];
               s.right_u = hi_u[d[121:114]];
               s.right_v = hi_v[d[121:114]];
            end else begin
               s = '0;
               s.span_left  = pesw_pkg::SpanMax;
               s.span_right = pesw_pkg::SpanMin;
            end
            pending_spans.push_back(s);
         end
      endcase
   endtask

   function automatic int rnd14();
      return int'($urandom_range(16383)) - 8192;
   endfunction

   // edge with on-screen rows mostly
   task automatic rand_edge(pesw_pkg::op_type op);
      int y0, y1;
      if ($urandom_range(9) < 8) begin
         y0 = int'($urandom_range(259)) - 10;
         y1 = y0 + int'($urandom_range(40)) - 20;
      end else begin
         y0 = rnd14(); y1 = rnd14();
      end
      if (y0 < -8192) y0 = -8192;
      if (y1 > 8191) y1 = 8191;
      if (y1 < -8192) y1 = -8192;
      if ($urandom_range(3) == 0)
         send_item(op, rnd14(), y0, rnd14(), rnd14(), rnd14(), y1, rnd14(), rnd14(), 0);
      else
         send_item(op, int'($urandom_range(400)) - 80, y0, rnd14(), rnd14(),
                   int'($urandom_range(400)) - 80, y1, rnd14(), rnd14(),
                   $urandom_range(255));
   endtask

   task automatic send_read(int row);
      send_item(pesw_pkg::OP_READ, rnd14(), rnd14(), rnd14(), rnd14(), rnd14(), rnd14(),
                rnd14(), rnd14(), row);
   endtask

   task automatic test_reset_state();
      send_read(0);
      send_read(NumRows - 1);
      send_read(NumRows);
      send_read(255);
   endtask

   task automatic test_directed_edges();
      // horizontal edge leaves spans alone
      send_item(pesw_pkg::OP_EDGE_UV, 5, 10, 1, 2, 50, 10, 3, 4, 0);
      send_read(10);
      // two shallow edges, both vertex orders
      send_item(pesw_pkg::OP_EDGE_UV, 10, 20, 100, -100, 60, 30, -200, 300, 0);
      send_item(pesw_pkg::OP_EDGE_UV, 90, 30, 8191, -8192, 30, 20, -8192, 8191, 0);
      send_read(25);
      // x only does not touch texture tables
      send_item(pesw_pkg::OP_EDGE_X, -50, 22, 7, 7, 200, 24, 9, 9, 0);
      send_read(23);
      // clipped above and below
      send_item(pesw_pkg::OP_EDGE_UV, -8192, -8192, -8192, -8192, 8191, 8191, 8191, 8191, 0);
      send_read(0);
      send_read(239);
      // off screen both ways
      send_item(pesw_pkg::OP_EDGE_UV, 0, 240, 0, 0, 0, 8000, 0, 0, 0);
      send_item(pesw_pkg::OP_EDGE_UV, 0, -1, 0, 0, 0, -8000, 0, 0, 0);
      send_read(0);
      // extreme x, from one end of the field range to the other
      send_item(pesw_pkg::OP_EDGE_UV, 8191, 0, 0, 0, -8192, 1, 0, 0, 0);
      send_read(1);
      // clear keeps textures
      send_item(pesw_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_read(25);
      send_read(200);
   endtask

   task automatic test_backpressure();
      long_hold = 1;
      for (int i = 0; i < 6; i++) send_read(i * 7);
      long_hold = 0;
   endtask

   task automatic test_random_polygons(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(19) == 0) begin
            send_item(pesw_pkg::OP_CLEAR, rnd14(), rnd14(), rnd14(), rnd14(), rnd14(),
                      rnd14(), rnd14(), rnd14(), $urandom_range(255));
            n++;
         end
         for (int e = 0; e < 4; e++) begin
            rand_edge($urandom_range(3) == 0 ? pesw_pkg::OP_EDGE_X : pesw_pkg::OP_EDGE_UV);
            n++;
         end
         repeat ($urandom_range(6, 2)) begin
            send_read($urandom_range(9) == 0 ? $urandom_range(255) : $urandom_range(239));
            n++;
         end
      end
   endtask

   // response sink with random stalls and long hold-offs during the back-pressure test
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            hold = 0;
            while (hold < 300) begin
               @(posedge clock);
               hold++;
            end
         end
         if (!quiet_tail && $urandom_range(99) < gap_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      span_rec got, exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_spans.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            exp_s = pending_spans.pop_front();
            if (got.span_left !== exp_s.span_left) begin
               $error("span_left exp %0d got %0d", exp_s.span_left, got.span_left);
               errors++;
            end
            if (got.span_right !== exp_s.span_right) begin
               $error("span_right exp %0d got %0d", exp_s.span_right, got.span_right);
               errors++;
            end
            if (got.left_u !== exp_s.left_u) begin
               $error("left_u exp %h got %h", exp_s.left_u, got.left_u);
               errors++;
            end
            if (got.left_v !== exp_s.left_v) begin
               $error("left_v exp %h got %h", exp_s.left_v, got.left_v);
               errors++;
            end
            if (got.right_u !== exp_s.right_u) begin
               $error("right_u exp %h got %h", exp_s.right_u, got.right_u);
               errors++;
            end
            if (got.right_v !== exp_s.right_v) begin
               $error("right_v exp %h got %h", exp_s.right_v, got.right_v);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < NumRows; i++) begin
         lo_u[i] = '0; lo_v[i] = '0; hi_u[i] = '0; hi_v[i] = '0;
      end
      clear_spans();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_edges();
      test_backpressure();
      test_random_polygons(1000);
      quiet_tail = 1;
      test_random_polygons(150);
      req_tvalid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (errors == 0 && pending_spans.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200ms;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
